// ----- rtl/matrix_ring_rotation_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Matrix ring rotation unit: assertion macros
// Shared assertion forms; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef MATRIX_RING_ROTATION_UNIT_MACROS_SVH
`define MATRIX_RING_ROTATION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix ring rotation package
// Types, register codes and sizing functions shared by the ring rotation RTL.
// ----------------------------------------------------------------------------
package mrr_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int SIZE_W   = 7;
	localparam int SIZE_MAX = (1 << SIZE_W) - 1;
	localparam int IDX_W    = 6;
	localparam int VAL_W    = 32;
	localparam int ROT_W    = 31;
	localparam int BIT_W    = $clog2(ROT_W);
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [1:0] REG_ROW_COUNT      = 2'd0;
	localparam logic [1:0] REG_COL_COUNT      = 2'd1;
	localparam logic [1:0] REG_ROTATION_COUNT = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic                    command;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    status;
	} rsp_t;

	typedef struct packed {
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
	} geom_t;

	typedef struct packed {
		logic command;
		logic oob;
	} loc_ctl_t;

	typedef enum logic [1:0] {
		MT_IDLE,
		MT_SETUP,
		MT_DIVIDE,
		MT_WRITE
	} mt_state_t;

	// Largest size the 7-bit count registers can express for a given maximum.
	function automatic int eff_size(input int max_size);
		return (max_size < SIZE_MAX) ? max_size : SIZE_MAX;
	endfunction

	function automatic int per_width(input int max_rows, input int max_cols);
		return $clog2(2 * (eff_size(max_rows) + eff_size(max_cols)));
	endfunction

	function automatic int ring_count(input int max_rows, input int max_cols);
		int er;
		int ec;
		er = eff_size(max_rows);
		ec = eff_size(max_cols);
		return ((er < ec) ? er : ec) / 2;
	endfunction

	function automatic int index_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ----- rtl/matrix_ring_rotation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix ring rotation unit
// Stores a matrix of signed words and returns elements as they would read
// after every concentric ring is rotated counter-clockwise a set number of
// steps.
// ----------------------------------------------------------------------------
//
// Channel   Dir      Handshake                    Payload
// cfg       in/out   psel, penable, pwrite        paddr, pwdata, prdata
// req       in       req_valid / req_ready        req (command, row, col, value)
// rsp       out      rsp_valid / rsp_ready        rsp (read_value, status)
//
// One request beat is taken per cycle unless busy or back-pressure holds
// req_ready low; a read result passes the locator stages and the store's
// read and result registers on its way to rsp, and write beats produce no result.
// After reset and after every register write, an offset sweep runs over
// every ring, one quotient bit per cycle through a shared restoring divider;
// req_ready is low for that time while register writes are still taken.
// A stalled rsp beat holds every stage behind it only as far as the bubbles
// in front allow; nothing is dropped or repeated.
//
`include "matrix_ring_rotation_unit_macros.svh"

module matrix_ring_rotation_unit import mrr_pkg::*; #(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp
);

	localparam int RINGS       = ring_count(MAX_ROWS, MAX_COLS);
	localparam int K_W         = index_width(RINGS);
	localparam int PER_W       = per_width(MAX_ROWS, MAX_COLS);
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int EFF_ROWS    = eff_size(MAX_ROWS);
	localparam int EFF_COLS    = eff_size(MAX_COLS);

	// ------------------------------------------------------------------
	// Register file. The registers read back as written; the sizes used
	// by the datapath are saturated into 1..MAX.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0] row_count_q;
	logic [SIZE_W-1:0] col_count_q;
	logic [ROT_W-1:0]  rotation_count_q;
	logic              cfg_wr;
	geom_t             geom;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q      <= SIZE_W'(64);
			col_count_q      <= SIZE_W'(64);
			rotation_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROW_COUNT:      row_count_q      <= pwdata[SIZE_W-1:0];
				REG_COL_COUNT:      col_count_q      <= pwdata[SIZE_W-1:0];
				REG_ROTATION_COUNT: rotation_count_q <= pwdata[ROT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_COUNT:      prdata = PDATA_W'(row_count_q);
			REG_COL_COUNT:      prdata = PDATA_W'(col_count_q);
			REG_ROTATION_COUNT: prdata = PDATA_W'(rotation_count_q);
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		if (row_count_q == '0)                       geom.rows = SIZE_W'(1);
		else if (row_count_q > SIZE_W'(EFF_ROWS))    geom.rows = SIZE_W'(EFF_ROWS);
		else                                         geom.rows = row_count_q;
		if (col_count_q == '0)                       geom.cols = SIZE_W'(1);
		else if (col_count_q > SIZE_W'(EFF_COLS))    geom.cols = SIZE_W'(EFF_COLS);
		else                                         geom.cols = col_count_q;
	end

	// ------------------------------------------------------------------
	// Per-ring rotation offsets. The table holds rotation_count modulo
	// each ring's perimeter, so the datapath only needs one conditional
	// subtract to wrap the source position.
	// ------------------------------------------------------------------
	logic             busy;
	logic             rm_rd_en;
	logic [K_W-1:0]   rm_rd_k;
	logic [PER_W-1:0] rm_data;

	mrr_modtab #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_modtab (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.rotation (rotation_count_q),
		.restart  (cfg_wr),
		.busy     (busy),
		.rd_en    (rm_rd_en),
		.rd_k     (rm_rd_k),
		.rd_data  (rm_data)
	);

	// ------------------------------------------------------------------
	// Locator pipeline: ring index, position along the ring, rotated
	// position, source coordinates and finally the store address.
	// Writes pass through unrotated so they reach the store in order
	// with the reads around them.
	// ------------------------------------------------------------------
	logic                    loc_in_valid;
	logic                    loc_in_ready;
	logic                    loc_valid;
	logic                    loc_ready;
	loc_ctl_t                loc_ctl;
	logic signed [VAL_W-1:0] loc_value;
	logic [AW-1:0]           loc_addr;

	assign loc_in_valid = req_valid && !busy;
	assign req_ready    = loc_in_ready && !busy;

	mrr_locate #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (loc_in_valid),
		.in_ready  (loc_in_ready),
		.in_beat   (req),
		.rm_rd_en  (rm_rd_en),
		.rm_rd_k   (rm_rd_k),
		.rm_data   (rm_data),
		.out_valid (loc_valid),
		.out_ready (loc_ready),
		.out_ctl   (loc_ctl),
		.out_value (loc_value),
		.out_addr  (loc_addr)
	);

	// ------------------------------------------------------------------
	// Element store and result register.
	// ------------------------------------------------------------------
	mrr_store #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (loc_valid),
		.in_ready  (loc_ready),
		.in_ctl    (loc_ctl),
		.in_value  (loc_value),
		.in_addr   (loc_addr),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_beat  (rsp)
	);

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// Any register write must restart the offset sweep and close the
	// request channel on the next cycle.
	`MRR_ASSERT_NEXT(a_cfg_restarts_sweep, cfg_wr, !req_ready, "request taken right after a register write")
	// An in-range position must map to an address inside the store.
	`MRR_ASSERT_SAME(a_addr_in_store, loc_valid && !loc_ctl.oob, 32'(loc_addr) < STORE_DEPTH, "source address beyond store")
	// An out-of-range read reports a zero value.
	`MRR_ASSERT_SAME(a_range_value_zero, rsp_valid && (rsp.status == STATUS_RANGE), rsp.read_value == '0, "range error with nonzero value")

endmodule

// ----- rtl/mrr_modtab.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring offset table
// Computes rotation_count mod perimeter for every ring, one bit per cycle.
// ----------------------------------------------------------------------------
module mrr_modtab import mrr_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  geom_t                                             geom,
	input  logic [ROT_W-1:0]                                  rotation,
	input  logic                                              restart,
	output logic                                              busy,
	input  logic                                              rd_en,
	input  logic [index_width(ring_count(MAX_ROWS, MAX_COLS))-1:0] rd_k,
	output logic [per_width(MAX_ROWS, MAX_COLS)-1:0]          rd_data
);

	localparam int RINGS = ring_count(MAX_ROWS, MAX_COLS);
	localparam int K_W   = index_width(RINGS);
	localparam int PER_W = per_width(MAX_ROWS, MAX_COLS);

	mt_state_t        state_q, state_d;
	logic [K_W-1:0]   k_q, k_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [PER_W-1:0] rem_q, rem_d;
	logic [PER_W-1:0] per_q, per_d;
	logic [PER_W-1:0] per_k;
	logic [PER_W:0]   sh;
	logic [PER_W:0]   per_x;
	logic             tab_we;

	logic [PER_W-1:0] tab [RINGS];

	// Perimeter of ring k: 2*(rows + cols) - 4 - 8*k.
	assign per_k = PER_W'({geom.rows, 1'b0}) + PER_W'({geom.cols, 1'b0})
		- PER_W'(4) - PER_W'({k_q, 3'b000});
	assign sh    = {rem_q, rotation[bit_q]};
	assign per_x = {1'b0, per_q};
	assign busy  = (state_q != MT_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MT_SETUP;
			k_q     <= '0;
			bit_q   <= '0;
			rem_q   <= '0;
			per_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			bit_q   <= bit_d;
			rem_q   <= rem_d;
			per_q   <= per_d;
		end
	end

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		bit_d   = bit_q;
		rem_d   = rem_q;
		per_d   = per_q;
		tab_we  = 1'b0;
		unique case (state_q)
			MT_IDLE: begin
			end
			MT_SETUP: begin
				per_d   = per_k;
				rem_d   = '0;
				bit_d   = BIT_W'(ROT_W - 1);
				state_d = MT_DIVIDE;
			end
			MT_DIVIDE: begin
				rem_d = (sh >= per_x) ? PER_W'(sh - per_x) : PER_W'(sh);
				if (bit_q == '0) begin
					state_d = MT_WRITE;
				end else begin
					bit_d = bit_q - BIT_W'(1);
				end
			end
			MT_WRITE: begin
				tab_we = 1'b1;
				if (k_q == K_W'(RINGS - 1)) begin
					state_d = MT_IDLE;
				end else begin
					k_d     = k_q + K_W'(1);
					state_d = MT_SETUP;
				end
			end
		endcase
		// Any register write invalidates the whole table.
		if (restart) begin
			state_d = MT_SETUP;
			k_d     = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab[k_q] <= rem_q;
		end
		if (rd_en) begin
			rd_data <= tab[rd_k];
		end
	end

endmodule

// ----- rtl/mrr_locate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring source locator
// Six-stage pipeline that maps a request position to its store address.
// ----------------------------------------------------------------------------
module mrr_locate import mrr_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  geom_t                                             geom,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  req_t                                              in_beat,
	output logic                                              rm_rd_en,
	output logic [index_width(ring_count(MAX_ROWS, MAX_COLS))-1:0] rm_rd_k,
	input  logic [per_width(MAX_ROWS, MAX_COLS)-1:0]          rm_data,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output loc_ctl_t                                          out_ctl,
	output logic signed [VAL_W-1:0]                           out_value,
	output logic [$clog2(MAX_ROWS * MAX_COLS)-1:0]            out_addr
);

	localparam int RINGS = ring_count(MAX_ROWS, MAX_COLS);
	localparam int K_W   = index_width(RINGS);
	localparam int PER_W = per_width(MAX_ROWS, MAX_COLS);
	localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);

	logic adv_1, adv_2, adv_3, adv_4, adv_5, adv_6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: request as received.
	req_t req_s1;

	// Stage 2: range check and ring index.
	logic                    cmd_s2, oob_s2, ring_s2;
	logic [SIZE_W-1:0]       r_s2, c_s2, k_s2;
	logic signed [VAL_W-1:0] val_s2;

	// Stage 3: position along the ring and perimeter.
	logic                    cmd_s3, oob_s3, ring_s3;
	logic [SIZE_W-1:0]       r_s3, c_s3, k_s3;
	logic signed [VAL_W-1:0] val_s3;
	logic [PER_W-1:0]        p_s3, per_s3, a_s3, b_s3, t2_s3, t3_s3;

	// Stage 4: rotated position.
	logic                    cmd_s4, oob_s4, ring_s4;
	logic [SIZE_W-1:0]       r_s4, c_s4, k_s4;
	logic signed [VAL_W-1:0] val_s4;
	logic [PER_W-1:0]        q_s4, per_s4, a_s4, b_s4, t2_s4, t3_s4;

	// Stage 5: source row and column.
	logic                    cmd_s5, oob_s5;
	logic [SIZE_W-1:0]       sr_s5, sc_s5;
	logic signed [VAL_W-1:0] val_s5;

	// Stage 6: store address.
	logic                    cmd_s6, oob_s6;
	logic signed [VAL_W-1:0] val_s6;
	logic [AW-1:0]           addr_s6;

	assign adv_6    = !v_s6 || out_ready;
	assign adv_5    = !v_s5 || adv_6;
	assign adv_4    = !v_s4 || adv_5;
	assign adv_3    = !v_s3 || adv_4;
	assign adv_2    = !v_s2 || adv_3;
	assign adv_1    = !v_s1 || adv_2;
	assign in_ready = adv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_1) v_s1 <= in_valid;
			if (adv_2) v_s2 <= v_s1;
			if (adv_3) v_s3 <= v_s2;
			if (adv_4) v_s4 <= v_s3;
			if (adv_5) v_s5 <= v_s4;
			if (adv_6) v_s6 <= v_s5;
		end
	end

	// ---- stage 1 -> 2 ----
	logic [SIZE_W-1:0] r1, c1, dr1, dc1, m1a, m1b, k1, layers1;
	logic              oob1, ring1;

	always_comb begin
		r1      = SIZE_W'(req_s1.row);
		c1      = SIZE_W'(req_s1.col);
		oob1    = (r1 >= geom.rows) || (c1 >= geom.cols);
		dr1     = geom.rows - SIZE_W'(1) - r1;
		dc1     = geom.cols - SIZE_W'(1) - c1;
		m1a     = (r1 < c1) ? r1 : c1;
		m1b     = (dr1 < dc1) ? dr1 : dc1;
		k1      = (m1a < m1b) ? m1a : m1b;
		layers1 = ((geom.rows < geom.cols) ? geom.rows : geom.cols) >> 1;
		ring1   = !oob1 && (req_s1.command == CMD_READ) && (k1 < layers1);
	end

	// ---- stage 2 -> 3 ----
	logic [SIZE_W-1:0] h2, w2, lr2, lc2, a2n, b2n;
	logic [PER_W-1:0]  a2, b2, p2;

	always_comb begin
		h2  = geom.rows - (k_s2 << 1);
		w2  = geom.cols - (k_s2 << 1);
		lr2 = r_s2 - k_s2;
		lc2 = c_s2 - k_s2;
		a2n = w2 - SIZE_W'(1);
		b2n = h2 - SIZE_W'(1);
		a2  = PER_W'(a2n);
		b2  = PER_W'(b2n);
		// Clockwise position from the ring's top-left corner.
		priority if (lr2 == '0) p2 = PER_W'(lc2);
		else if (lc2 == a2n)    p2 = a2 + PER_W'(lr2);
		else if (lr2 == b2n)    p2 = a2 + b2 + PER_W'(a2n - lc2);
		else                    p2 = (a2 << 1) + b2 + PER_W'(b2n - lr2);
	end

	assign rm_rd_en = adv_3;
	assign rm_rd_k  = k_s2[K_W-1:0];

	// ---- stage 3 -> 4 ----
	logic [PER_W:0]   sum3, per3x;
	logic [PER_W-1:0] q3;

	always_comb begin
		sum3  = {1'b0, p_s3} + {1'b0, rm_data};
		per3x = {1'b0, per_s3};
		q3    = (sum3 >= per3x) ? PER_W'(sum3 - per3x) : PER_W'(sum3);
	end

	// ---- stage 4 -> 5 ----
	logic [PER_W-1:0]  lr4, lc4;
	logic [SIZE_W-1:0] sr4, sc4;

	always_comb begin
		priority if (q_s4 < a_s4) begin
			lr4 = '0;
			lc4 = q_s4;
		end else if (q_s4 < t2_s4) begin
			lr4 = q_s4 - a_s4;
			lc4 = a_s4;
		end else if (q_s4 < t3_s4) begin
			lr4 = b_s4;
			lc4 = t3_s4 - q_s4;
		end else begin
			lr4 = per_s4 - q_s4;
			lc4 = '0;
		end
		sr4 = ring_s4 ? SIZE_W'(lr4) + k_s4 : r_s4;
		sc4 = ring_s4 ? SIZE_W'(lc4) + k_s4 : c_s4;
	end

	// ---- stage 5 -> 6 ----
	logic [AW-1:0] addr5;

	assign addr5 = AW'(sr_s5 * MAX_COLS) + AW'(sc_s5);

	always_ff @(posedge clk) begin
		if (adv_1) begin
			req_s1 <= in_beat;
		end
		if (adv_2) begin
			cmd_s2  <= req_s1.command;
			oob_s2  <= oob1;
			ring_s2 <= ring1;
			r_s2    <= r1;
			c_s2    <= c1;
			k_s2    <= k1;
			val_s2  <= req_s1.value;
		end
		if (adv_3) begin
			cmd_s3  <= cmd_s2;
			oob_s3  <= oob_s2;
			ring_s3 <= ring_s2;
			r_s3    <= r_s2;
			c_s3    <= c_s2;
			k_s3    <= k_s2;
			val_s3  <= val_s2;
			p_s3    <= p2;
			per_s3  <= (a2 + b2) << 1;
			a_s3    <= a2;
			b_s3    <= b2;
			t2_s3   <= a2 + b2;
			t3_s3   <= (a2 << 1) + b2;
		end
		if (adv_4) begin
			cmd_s4  <= cmd_s3;
			oob_s4  <= oob_s3;
			ring_s4 <= ring_s3;
			r_s4    <= r_s3;
			c_s4    <= c_s3;
			k_s4    <= k_s3;
			val_s4  <= val_s3;
			q_s4    <= q3;
			per_s4  <= per_s3;
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			t2_s4   <= t2_s3;
			t3_s4   <= t3_s3;
		end
		if (adv_5) begin
			cmd_s5 <= cmd_s4;
			oob_s5 <= oob_s4;
			val_s5 <= val_s4;
			sr_s5  <= sr4;
			sc_s5  <= sc4;
		end
		if (adv_6) begin
			cmd_s6  <= cmd_s5;
			oob_s6  <= oob_s5;
			val_s6  <= val_s5;
			addr_s6 <= addr5;
		end
	end

	assign out_valid       = v_s6;
	assign out_ctl.command = cmd_s6;
	assign out_ctl.oob     = oob_s6;
	assign out_value       = val_s6;
	assign out_addr        = addr_s6;

endmodule

// ----- rtl/mrr_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix store
// Single-port element memory with registered read and the result register.
// ----------------------------------------------------------------------------
module mrr_store import mrr_pkg::*; #(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  loc_ctl_t                               in_ctl,
	input  logic signed [VAL_W-1:0]                in_value,
	input  logic [$clog2(MAX_ROWS * MAX_COLS)-1:0] in_addr,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output rsp_t                                   out_beat
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];

	logic                         adv_7, adv_8;
	logic                         v_s7, v_s8;
	logic                         oob_s7;
	logic signed [DATA_WIDTH-1:0] rdata_s7;
	rsp_t                         rsp_s8;

	assign adv_8    = !v_s8 || out_ready;
	assign adv_7    = !v_s7 || adv_8;
	assign in_ready = adv_7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			// Writes leave the pipeline here; only reads carry on.
			if (adv_7) v_s7 <= in_valid && (in_ctl.command == CMD_READ);
			if (adv_8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_7 && in_valid) begin
			if (in_ctl.command == CMD_WRITE) begin
				if (!in_ctl.oob) begin
					mem[in_addr] <= DATA_WIDTH'(in_value);
				end
			end else begin
				rdata_s7 <= mem[in_addr];
			end
		end
		if (adv_7) begin
			oob_s7 <= in_ctl.oob;
		end
		if (adv_8) begin
			rsp_s8.status     <= oob_s7 ? STATUS_RANGE : STATUS_OK;
			rsp_s8.read_value <= oob_s7 ? '0 : VAL_W'(rdata_s7);
		end
	end

	assign out_valid = v_s8;
	assign out_beat  = rsp_s8;

endmodule

// ----- test/matrix_ring_rotation_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix ring rotation unit testbench
// Drives write and read beats through the request channel and checks each
// read result against a local predictor of the rotated matrix. The geometry
// and rotation registers are rewritten through the APB port between phases.
// Both channels see random stalls, and one long result stall is included.
// ----------------------------------------------------------------------------
module matrix_ring_rotation_unit_tb;
	import mrr_pkg::*;

	// Run length and pacing.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned STORE_WORDS  = MAX_ROWS_DEF * MAX_COLS_DEF;

	// Every input of the block starts at a known value.
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;

	matrix_ring_rotation_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Mirror of the configuration registers, starting from their reset values.
	logic [SIZE_W-1:0] rows_reg = SIZE_W'(MAX_ROWS_DEF);
	logic [SIZE_W-1:0] cols_reg = SIZE_W'(MAX_COLS_DEF);
	logic [ROT_W-1:0]  rot_reg  = '0;

	// Predicted matrix contents, updated as write beats are accepted.
	logic signed [VAL_W-1:0] shadow_matrix [STORE_WORDS];

	// Stimulus side bookkeeping: which elements have been written so far. In-range
	// reads are only generated when their source element is known to hold data.
	bit          written_map [STORE_WORDS];
	int unsigned written_list[$];

	req_t pending_beats[$];
	rsp_t expected_reads[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          no_idle        = 1'b0;
	bit          hold_armed     = 1'b0;
	bit          hold_done      = 1'b0;
	int unsigned hold_left      = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Size registers saturate into 1..limit.
	function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw, int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// Returns the store address of the element that lands on (r, c) after the
	// rings are rotated by rot steps. With backward set the shift is undone
	// instead, which gives the position from which a given element is read.
	// Elements off every full ring map to themselves.
	function automatic int unsigned ring_source(int unsigned rows, int unsigned cols,
			int unsigned r, int unsigned c, logic [ROT_W-1:0] rot, bit backward);
		int unsigned k, layers, h, w, lr, lc, a, b, per, p, s, q;
		k = (r < c) ? r : c;
		if (rows - 1 - r < k)
			k = rows - 1 - r;
		if (cols - 1 - c < k)
			k = cols - 1 - c;
		layers = ((rows < cols) ? rows : cols) / 2;
		if (k >= layers)
			return r * MAX_COLS_DEF + c;

		// Position along the ring, clockwise from its top-left corner.
		h   = rows - 2 * k;
		w   = cols - 2 * k;
		lr  = r - k;
		lc  = c - k;
		a   = w - 1;
		b   = h - 1;
		per = 2 * (h + w) - 4;
		if (lr == 0)
			p = lc;
		else if (lc == w - 1)
			p = a + lr;
		else if (lr == h - 1)
			p = a + b + (w - 1 - lc);
		else
			p = 2 * a + b + (h - 1 - lr);

		s = rot % per;
		if (backward)
			s = (per - s) % per;
		q = (p + s) % per;

		if (q < a) begin
			lr = 0;
			lc = q;
		end else if (q < a + b) begin
			lr = q - a;
			lc = w - 1;
		end else if (q < 2 * a + b) begin
			lr = h - 1;
			lc = w - 1 - (q - a - b);
		end else begin
			lr = h - 1 - (q - 2 * a - b);
			lc = 0;
		end
		return (lr + k) * MAX_COLS_DEF + (lc + k);
	endfunction

	// Applies one accepted beat to the predicted matrix. Reads queue the
	// result that the block owes; writes owe nothing.
	function automatic void predict_beat(req_t beat);
		int unsigned rows, cols;
		rsp_t        want;
		rows = clamp_size(rows_reg, MAX_ROWS_DEF);
		cols = clamp_size(cols_reg, MAX_COLS_DEF);
		if (beat.command == CMD_WRITE) begin
			if (beat.row < rows && beat.col < cols)
				shadow_matrix[beat.row * MAX_COLS_DEF + beat.col] = beat.value;
		end else if (beat.row >= rows || beat.col >= cols) begin
			want.read_value = '0;
			want.status     = STATUS_RANGE;
			expected_reads.push_back(want);
		end else begin
			want.read_value = shadow_matrix[ring_source(rows, cols, beat.row, beat.col,
				rot_reg, 1'b0)];
			want.status     = STATUS_OK;
			expected_reads.push_back(want);
		end
	endfunction

	// Queues one beat for the driver. Returns 0 for a write outside the
	// current size, which the block drops without effect.
	function automatic bit queue_beat(logic cmd, int unsigned r, int unsigned c,
			logic [VAL_W-1:0] val);
		req_t        beat;
		int unsigned addr;
		beat.command = cmd;
		beat.row     = r[IDX_W-1:0];
		beat.col     = c[IDX_W-1:0];
		beat.value   = val;
		pending_beats.push_back(beat);
		if (cmd == CMD_WRITE) begin
			if (r >= clamp_size(rows_reg, MAX_ROWS_DEF) || c >= clamp_size(cols_reg, MAX_COLS_DEF))
				return 1'b0;
			addr = r * MAX_COLS_DEF + c;
			if (!written_map[addr]) begin
				written_map[addr] = 1'b1;
				written_list.push_back(addr);
			end
		end
		return 1'b1;
	endfunction

	function automatic void log_mismatch(string detail);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", detail);
	endfunction

	// Request driver. The accepted beat is handed to the predictor at the edge
	// that takes it, and the next beat (or a random gap) follows at once.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_beat(req);
			if (!req_valid || req_ready) begin
				if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
					req       <= pending_beats.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back pressure. Once armed, the next accepted request starts a
	// long stall so that the pipeline fills and the request channel backs up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_armed && !hold_done && req_valid && req_ready) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 30);
			end
		end
	end

	// Result monitor: every result beat is checked against the oldest owed read.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_reads.size() == 0) begin
				log_mismatch($sformatf("unexpected result beat: value %h status %b",
					rsp.read_value, rsp.status));
			end else begin
				want = expected_reads.pop_front();
				if (rsp.read_value !== want.read_value || rsp.status !== want.status)
					log_mismatch($sformatf(
						"result mismatch: expected value %h status %b, got value %h status %b",
						want.read_value, want.status, rsp.read_value, rsp.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Waits until every queued beat is taken and every owed result has come.
	// Polling on the falling edge keeps clear of the driver's updates.
	task automatic wait_drain();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || req_valid || expected_reads.size() != 0);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge that closes the access cycle since pready is always high.
	task automatic write_register(input logic [1:0] index, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({index, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			REG_ROW_COUNT:      rows_reg = data[SIZE_W-1:0];
			REG_COL_COUNT:      cols_reg = data[SIZE_W-1:0];
			REG_ROTATION_COUNT: rot_reg  = data[ROT_W-1:0];
			default: ;
		endcase
	endtask

	// Registers change only with the block idle. A write beat may still be in
	// the pipeline after the last result, so a few more cycles go by first.
	task automatic set_geometry(input logic [PDATA_W-1:0] rows_w,
			input logic [PDATA_W-1:0] cols_w, input logic [PDATA_W-1:0] rot_w);
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_register(REG_ROW_COUNT, rows_w);
		write_register(REG_COL_COUNT, cols_w);
		write_register(REG_ROTATION_COUNT, rot_w);
	endtask

	initial begin
		int unsigned      random_items, phase, rows, cols, n, i, tries, r, c, addr;
		logic [PDATA_W-1:0] rows_w, cols_w, rot_w;
		random_items = 0;
		phase        = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first at the reset geometry of 64 x 64 with no
		// rotation: the corner positions with the extreme data words.
		void'(queue_beat(CMD_WRITE, 0, 0, 32'h7FFF_FFFF));
		void'(queue_beat(CMD_WRITE, 63, 63, 32'h8000_0000));
		void'(queue_beat(CMD_WRITE, 0, 63, 32'hFFFF_FFFF));
		void'(queue_beat(CMD_WRITE, 63, 0, 32'h0000_0000));
		void'(queue_beat(CMD_READ, 0, 0, 32'h0000_0000));
		void'(queue_beat(CMD_READ, 63, 63, 32'hFFFF_FFFF));
		void'(queue_beat(CMD_READ, 0, 63, 32'h0000_0000));
		void'(queue_beat(CMD_READ, 63, 0, 32'hFFFF_FFFF));

		// Row count of zero saturates to one and 127 columns saturate to 64.
		// A single row holds no full ring, so every element reads unrotated
		// even at the largest rotation count. Rows past row zero lie outside the size:
		// those reads report a range error and the write is dropped.
		set_geometry(32'd0, 32'd127, 32'hFFFF_FFFF);
		void'(queue_beat(CMD_READ, 0, 0, 32'h1234_5678));
		void'(queue_beat(CMD_READ, 0, 63, 32'h0));
		void'(queue_beat(CMD_READ, 1, 0, 32'h0));
		void'(queue_beat(CMD_WRITE, 5, 5, 32'hDEAD_BEEF));
		void'(queue_beat(CMD_READ, 63, 63, 32'h0));
		void'(queue_beat(CMD_WRITE, 0, 5, 32'h0BAD_F00D));
		void'(queue_beat(CMD_READ, 0, 5, 32'h0));

		// 3 x 3 rotated by one: the centre stays put, and the top-left corner
		// reads the element to its right.
		set_geometry(32'd3, 32'd3, 32'd1);
		void'(queue_beat(CMD_WRITE, 1, 1, 32'h5555_AAAA));
		void'(queue_beat(CMD_WRITE, 0, 1, 32'hAAAA_5555));
		void'(queue_beat(CMD_READ, 1, 1, 32'h0));
		void'(queue_beat(CMD_READ, 0, 0, 32'h0));

		// Random phases. Each one picks a geometry and rotation, loads the
		// matrix, then mixes read-backs with fresh writes and range errors.
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					rows_w = 64;
					cols_w = 64;
				end
				1: begin
					rows_w = 0;
					cols_w = 127;
				end
				2: begin
					rows_w = 2;
					cols_w = 64;
				end
				3: begin
					rows_w = 64;
					cols_w = 1;
				end
				4: begin
					rows_w = $urandom_range(0, 127);
					cols_w = $urandom_range(0, 127);
				end
				default: begin
					rows_w = $urandom_range(1, 9);
					cols_w = $urandom_range(1, 9);
				end
			endcase
			case ($urandom_range(0, 4))
				0: rot_w = 0;
				1: rot_w = 1;
				2: rot_w = 32'h7FFF_FFFF;
				3: rot_w = $urandom;
				default: rot_w = $urandom_range(0, 40);
			endcase
			set_geometry(rows_w, cols_w, rot_w);
			rows = clamp_size(rows_reg, MAX_ROWS_DEF);
			cols = clamp_size(cols_reg, MAX_COLS_DEF);

			// One phase runs with no gaps on either side.
			no_idle = (phase == 2);

			// Small matrices are loaded whole; large ones get a scattering.
			if (rows * cols <= 100) begin
				for (r = 0; r < rows; r++)
					for (c = 0; c < cols; c++)
						random_items += queue_beat(CMD_WRITE, r, c, $urandom);
			end else begin
				repeat (48)
					random_items += queue_beat(CMD_WRITE, $urandom_range(0, rows - 1),
						$urandom_range(0, cols - 1), $urandom);
			end

			// In the second phase the load completes first, so that the long
			// result stall lands on a stream of reads.
			if (phase == 1) begin
				wait_drain();
				hold_armed = 1'b1;
			end

			n = $urandom_range(40, 90);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 19))
					12, 13, 14: begin
						random_items += queue_beat(CMD_WRITE, $urandom_range(0, rows - 1),
							$urandom_range(0, cols - 1), $urandom);
					end
					15, 16: begin
						if (rows < MAX_ROWS_DEF)
							random_items += queue_beat(CMD_READ, $urandom_range(rows, 63),
								$urandom_range(0, 63), $urandom);
						else if (cols < MAX_COLS_DEF)
							random_items += queue_beat(CMD_READ, $urandom_range(0, 63),
								$urandom_range(cols, 63), $urandom);
					end
					17: begin
						if (rows < MAX_ROWS_DEF)
							void'(queue_beat(CMD_WRITE, $urandom_range(rows, 63),
								$urandom_range(0, 63), $urandom));
					end
					18, 19: begin
						// Any position at all, kept only if it cannot touch an
						// element that was never written.
						r = $urandom_range(0, 63);
						c = $urandom_range(0, 63);
						if (r >= rows || c >= cols ||
								written_map[ring_source(rows, cols, r, c, rot_reg, 1'b0)])
							random_items += queue_beat(CMD_READ, r, c, $urandom);
					end
					default: begin
						// Pick a written element inside the size and read it
						// back from wherever the rotation has moved it.
						for (tries = 0; tries < 32; tries++) begin
							addr = written_list[$urandom_range(0, written_list.size() - 1)];
							r    = addr / MAX_COLS_DEF;
							c    = addr % MAX_COLS_DEF;
							if (r < rows && c < cols) begin
								addr = ring_source(rows, cols, r, c, rot_reg, 1'b1);
								random_items += queue_beat(CMD_READ, addr / MAX_COLS_DEF,
									addr % MAX_COLS_DEF, $urandom);
								break;
							end
						end
					end
				endcase
			end
			phase++;
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- matrix_ring_rotation_unit.f -----
+incdir+rtl
rtl/mrr_pkg.sv
rtl/mrr_modtab.sv
rtl/mrr_locate.sv
rtl/mrr_store.sv
rtl/matrix_ring_rotation_unit.sv
test/matrix_ring_rotation_unit_tb.sv
